FILE: rtl/bafm_pkg.sv
// Shared types and constants for the buddy allocator with fit modes.
// Holds the command enum and status struct passed between controller and datapath.
// No dependencies.
package bafm_pkg;

  localparam int DEF_MIN_BLOCK_LOG2 = 5;
  localparam int DEF_LEVELS         = 10;
  localparam int DEF_HEADER_BYTES   = 16;

  localparam int IN_W  = 32;
  localparam int OUT_W = 56;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_SPARE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALLOC_OK,
    KIND_FREE_OK,
    KIND_NOMEM,
    KIND_INVALID
  } kind_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SCAN_RD,
    CMD_SCAN_EVAL,
    CMD_SPLIT,
    CMD_SET_ALLOC_OK,
    CMD_SET_NOMEM,
    CMD_SET_INVALID,
    CMD_FREE_RD,
    CMD_FREE_EVAL,
    CMD_BUDDY_RD,
    CMD_BUDDY_EVAL,
    CMD_FINISH
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic addr_ok;
    logic scan_end;
    logic found_v;
    logic split_more;
    logic tag_ok;
    logic merge_ok;
    logic lvl_top;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/bafm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bafm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bafm_ctrl.sv
// Controller state machine for the buddy allocator.
// Depends on bafm_pkg; drives commands into bafm_dp.
module bafm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bafm_pkg::dp_stat_t stat,
  output bafm_pkg::cmd_t    cmd
);
  import bafm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat.is_free) begin
          state_nxt = S_F_RD;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        cmd       = CMD_SCAN_EVAL;
        state_nxt = stat.scan_end ? S_A_SPLIT : S_A_RD;
      end
      S_A_SPLIT: begin
        if (!stat.found_v) begin
          cmd       = CMD_SET_NOMEM;
          state_nxt = S_FINISH;
        end else if (stat.split_more) begin
          cmd = CMD_SPLIT;
        end else begin
          cmd       = CMD_SET_ALLOC_OK;
          state_nxt = S_FINISH;
        end
      end
      S_F_RD: begin
        if (!stat.addr_ok) begin
          cmd       = CMD_SET_INVALID;
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_FREE_RD;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        cmd       = CMD_FREE_EVAL;
        state_nxt = stat.tag_ok ? S_M_RD : S_FINISH;
      end
      S_M_RD: begin
        if (stat.lvl_top) begin
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_BUDDY_RD;
          state_nxt = S_M_CHK;
        end
      end
      S_M_CHK: begin
        cmd       = CMD_BUDDY_EVAL;
        state_nxt = stat.merge_ok ? S_M_RD : S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

FILE: rtl/bafm_dp.sv
// Datapath for the buddy allocator: tag RAM, scan/split/merge registers,
// free byte counter and output register. Depends on bafm_pkg and bafm_ram.
module bafm_dp #(
  parameter int MIN_BLOCK_LOG2 = bafm_pkg::DEF_MIN_BLOCK_LOG2,
  parameter int LEVELS         = bafm_pkg::DEF_LEVELS,
  parameter int HEADER_BYTES   = bafm_pkg::DEF_HEADER_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bafm_pkg::cmd_t              cmd,
  output bafm_pkg::dp_stat_t          stat,
  input  logic [bafm_pkg::IN_W-1:0]   in_data,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bafm_pkg::OUT_W-1:0]  out_tdata
);
  import bafm_pkg::*;

  localparam int GRANULES = 1 << LEVELS;
  localparam int LVW      = $clog2(LEVELS + 1);
  localparam int TW       = LVW + 2;
  localparam int GW       = LEVELS + 1;
  localparam int SZW      = MIN_BLOCK_LOG2 + LEVELS + 1;
  localparam int CW       = (SZW > 18) ? SZW : 18;
  localparam logic [LVW-1:0] LVL_TOP  = LVW'(LEVELS);
  localparam logic [CW-1:0]  SPACE_C  = CW'(1) << (MIN_BLOCK_LOG2 + LEVELS);
  localparam logic [15:0]    HDR16    = 16'(HEADER_BYTES);
  localparam logic [15:0]    GMASK16  = 16'((1 << MIN_BLOCK_LOG2) - 1);

  // tag word: {head, occupied, level}
  logic              we;
  logic [LEVELS-1:0] waddr, raddr;
  logic [TW-1:0]     wdata, rdata;

  bafm_ram #(.WIDTH(TW), .DEPTH(GRANULES)) u_tags (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic [1:0]        fit_sel_r;
  logic [GW-1:0]     clr_r;
  logic              op_r;
  logic [16:0]       need_r;
  logic [14:0]       addr_r;
  logic [GW-1:0]     g_r;
  logic [LEVELS-1:0] fg_r;
  logic [LVW-1:0]    lvl_r;
  logic              found_v_r;
  kind_t             kind_r;
  logic [15:0]       free_total_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic [OUT_W-1:0]  out_data_nxt;

  function automatic logic [CW-1:0] size_of(input logic [LVW-1:0] l);
    size_of = CW'(1) << (MIN_BLOCK_LOG2 + int'(l));
  endfunction

  // read tag fields
  logic           t_head, t_occ;
  logic [LVW-1:0] t_lvl_raw, t_lvl;
  assign t_head    = rdata[TW-1];
  assign t_occ     = rdata[TW-2];
  assign t_lvl_raw = rdata[LVW-1:0];
  assign t_lvl     = (t_lvl_raw > LVL_TOP) ? LVL_TOP : t_lvl_raw;

  // scan step
  logic          fits, take, first_mode;
  logic [GW-1:0] g_next;
  assign fits       = t_head && !t_occ && (size_of(t_lvl) >= CW'(need_r));
  assign first_mode = (fit_sel_r != FIT_BEST) && (fit_sel_r != FIT_WORST);
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_v_r) take = 1'b1;
      else if (fit_sel_r == FIT_BEST && t_lvl < lvl_r) take = 1'b1;
      else if (fit_sel_r == FIT_WORST && t_lvl > lvl_r) take = 1'b1;
    end
  end
  assign g_next = t_head ? (g_r + (GW'(1) << t_lvl)) : (g_r + GW'(1));

  // free address check
  logic [15:0] off16, gfull16;
  logic        addr_ok;
  assign off16   = {1'b0, addr_r} - HDR16;
  assign gfull16 = off16 >> MIN_BLOCK_LOG2;
  assign addr_ok = ({1'b0, addr_r} >= HDR16) && ((off16 & GMASK16) == 16'd0) &&
                   (CW'(off16) < SPACE_C);

  // merge step
  logic [LEVELS-1:0] buddy;
  logic              merge_ok;
  assign buddy    = fg_r ^ (LEVELS'(1) << lvl_r);
  assign merge_ok = t_head && !t_occ && (t_lvl_raw == lvl_r);

  logic [CW-1:0] sz_cur;
  logic [CW-1:0] data_wide;
  assign sz_cur    = size_of(lvl_r);
  assign data_wide = (CW'(fg_r) << MIN_BLOCK_LOG2) + CW'(HEADER_BYTES);

  always_comb begin
    stat.clr_done   = (clr_r == GW'(GRANULES - 1));
    stat.is_free    = (op_r == OP_FREE);
    stat.addr_ok    = addr_ok;
    stat.scan_end   = (take && !found_v_r && first_mode) || g_next[LEVELS];
    stat.found_v    = found_v_r;
    stat.split_more = (lvl_r != '0) && (sz_cur >= CW'({need_r, 1'b0}));
    stat.tag_ok     = t_head && t_occ;
    stat.merge_ok   = merge_ok;
    stat.lvl_top    = (lvl_r == LVL_TOP);
    stat.out_busy   = out_valid_r && !out_tready;
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = fg_r;
    wdata = '0;
    raddr = g_r[LEVELS-1:0];
    unique case (cmd)
      CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[LEVELS-1:0];
        wdata = (clr_r == '0) ? {1'b1, 1'b0, LVL_TOP} : '0;
      end
      CMD_SPLIT: begin
        we    = 1'b1;
        waddr = fg_r + (LEVELS'(1) << (lvl_r - LVW'(1)));
        wdata = {1'b1, 1'b0, lvl_r - LVW'(1)};
      end
      CMD_FREE_RD: raddr = LEVELS'(gfull16);
      CMD_BUDDY_RD: raddr = buddy;
      CMD_BUDDY_EVAL: begin
        // higher half of the merged pair stops being a head
        we    = merge_ok;
        waddr = (buddy < fg_r) ? fg_r : buddy;
      end
      CMD_FINISH: begin
        we    = (kind_r == KIND_ALLOC_OK) || (kind_r == KIND_FREE_OK);
        wdata = {1'b1, (kind_r == KIND_ALLOC_OK), lvl_r};
      end
      default: ;
    endcase
  end

  logic [15:0] free_fin;
  assign free_fin = (kind_r == KIND_ALLOC_OK) ? free_total_r - 16'(sz_cur) : free_total_r;

  // result beat and its valid flag
  assign out_valid_nxt = (cmd == CMD_FINISH) || (out_valid_r && !out_tready);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[48:33] = free_fin;
    case (kind_r)
      KIND_ALLOC_OK: begin
        out_data_nxt[1:0]   = ST_OK;
        out_data_nxt[16:2]  = data_wide[14:0];
        out_data_nxt[32:17] = 16'(sz_cur);
      end
      KIND_FREE_OK: out_data_nxt[1:0] = ST_OK;
      KIND_NOMEM:   out_data_nxt[1:0] = ST_NOMEM;
      default:      out_data_nxt[1:0] = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_sel_r    <= FIT_FIRST;
      clr_r        <= '0;
      op_r         <= OP_ALLOC;
      found_v_r    <= 1'b0;
      kind_r       <= KIND_NOMEM;
      free_total_r <= 16'(SPACE_C);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) fit_sel_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
      unique case (cmd)
        CMD_CLEAR: clr_r <= clr_r + GW'(1);
        CMD_LOAD: begin
          op_r      <= in_data[0];
          need_r    <= 17'(in_data[16:1]) + 17'(HEADER_BYTES);
          addr_r    <= in_data[31:17];
          g_r       <= '0;
          found_v_r <= 1'b0;
        end
        CMD_SCAN_EVAL: begin
          g_r <= g_next;
          if (take) begin
            found_v_r <= 1'b1;
            fg_r      <= g_r[LEVELS-1:0];
            lvl_r     <= t_lvl;
          end
        end
        CMD_SPLIT:        lvl_r <= lvl_r - LVW'(1);
        CMD_SET_ALLOC_OK: kind_r <= KIND_ALLOC_OK;
        CMD_SET_NOMEM:    kind_r <= KIND_NOMEM;
        CMD_SET_INVALID:  kind_r <= KIND_INVALID;
        CMD_FREE_RD:      fg_r <= LEVELS'(gfull16);
        CMD_FREE_EVAL: begin
          lvl_r <= t_lvl;
          if (t_head && t_occ) begin
            kind_r       <= KIND_FREE_OK;
            free_total_r <= free_total_r + 16'(size_of(t_lvl));
          end else begin
            kind_r <= KIND_INVALID;
          end
        end
        CMD_BUDDY_EVAL: begin
          if (merge_ok) begin
            lvl_r <= lvl_r + LVW'(1);
            if (buddy < fg_r) fg_r <= buddy;
          end
        end
        CMD_FINISH: begin
          free_total_r <= free_fin;
          out_data_r   <= out_data_nxt;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/buddy_allocator_fit_modes.sv
// Top level of the binary buddy allocator with selectable fit mode.
// Depends on bafm_pkg, bafm_ctrl, bafm_dp (which holds bafm_ram).
//
// One operation is taken at a time on the in_ stream and gives exactly one
// result beat on the out_ stream. After reset a clearing pass writes all
// 2^LEVELS tag entries before the first beat is taken. An allocate loads the
// beat, reads and then evaluates the tag of each visited block (the tag RAM
// read is registered), takes a split step for each split level, commits, and
// issues the result. A free ends early on a bad address or when the granule
// is not an occupied head; otherwise it reads and evaluates each buddy and
// merges until a buddy is not free at its level or the full space is reached.
// The worst case is a scan over a space split into single granules. A result
// is issued only when the previous one is not still waiting on out_tready. The
// fit mode may be written on cfg_ whenever no operation is in flight.
module buddy_allocator_fit_modes #(
  parameter int MIN_BLOCK_LOG2 = bafm_pkg::DEF_MIN_BLOCK_LOG2,
  parameter int LEVELS         = bafm_pkg::DEF_LEVELS,
  parameter int HEADER_BYTES   = bafm_pkg::DEF_HEADER_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_data,   // fit selection
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] op, [16:1] request_bytes, [31:17] free_address
  input  logic [bafm_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] status, [16:2] data_address, [32:17] granted_bytes,
  // [48:33] free_bytes, [55:49] zero
  output logic [bafm_pkg::OUT_W-1:0] out_tdata
);
  import bafm_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bafm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bafm_dp #(
    .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
    .LEVELS        (LEVELS),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a beat while an operation was in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_OK || out_tdata[1:0] == ST_NOMEM ||
                    out_tdata[1:0] == ST_INVALID))
    else $error("undefined status code");

  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[32:17] == 16'd0)
    else $error("granted bytes on an error result");

endmodule

FILE: verif/tb.sv
// Self-checking bench for buddy_allocator_fit_modes: random and directed
// allocate/free beats checked against an in-bench buddy model via a scoreboard.
// Depends on bafm_pkg and the allocator RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int GRAN = 1 << bafm_pkg::DEF_LEVELS;
  localparam int MINL = bafm_pkg::DEF_MIN_BLOCK_LOG2;
  localparam int LVLS = bafm_pkg::DEF_LEVELS;
  localparam int HDR  = bafm_pkg::DEF_HEADER_BYTES;
  localparam int SPACE = 1 << (MINL + LVLS);

  bit        head[GRAN];
  bit        occ[GRAN];
  int        lvl_of[GRAN];
  int        free_sum;
  logic [1:0] mode;
  logic [bafm_pkg::OUT_W-1:0] pending[$];
  int        errors;
  int        n_ok, n_nomem, n_bad;
  int        live[$];   // data addresses currently held

  function void clear();
    foreach (head[i]) begin
      head[i] = 0; occ[i] = 0; lvl_of[i] = 0;
    end
    head[0] = 1; lvl_of[0] = LVLS;
    free_sum = SPACE; mode = bafm_pkg::FIT_FIRST;
    pending.delete(); live.delete();
  endfunction

  function int pick(int need);
    int g, found, fsz, sz;
    g = 0; found = GRAN; fsz = 0;
    while (g < GRAN) begin
      if (!head[g]) begin
        g++;
        continue;
      end
      sz = 1 << (MINL + lvl_of[g]);
      if (!occ[g] && sz >= need) begin
        if (found == GRAN) begin
          found = g; fsz = sz;
          if (mode != bafm_pkg::FIT_BEST && mode != bafm_pkg::FIT_WORST) return found;
        end else if (mode == bafm_pkg::FIT_BEST && sz < fsz) begin
          found = g; fsz = sz;
        end else if (mode == bafm_pkg::FIT_WORST && sz > fsz) begin
          found = g; fsz = sz;
        end
      end
      g += 1 << lvl_of[g];
    end
    return found;
  endfunction

  function void note_input(logic [bafm_pkg::IN_W-1:0] beat);
    logic [1:0] st;
    int addr_o, granted, need, g, l, b, a, off;
    bit ok;
    logic [bafm_pkg::OUT_W-1:0] beat_exp;
    st = bafm_pkg::ST_OK; addr_o = 0; granted = 0;
    if (beat[0] == bafm_pkg::OP_ALLOC) begin
      need = int'(beat[16:1]) + HDR;
      g = pick(need);
      if (g >= GRAN) st = bafm_pkg::ST_NOMEM;
      else begin
        l = lvl_of[g];
        while (l > 0 && (1 << (MINL + l)) >= need * 2) begin
          l--;
          b = g + (1 << l);
          head[b] = 1; occ[b] = 0; lvl_of[b] = l;
        end
        lvl_of[g] = l; occ[g] = 1;
        granted = 1 << (MINL + l);
        free_sum -= granted;
        addr_o = (g << MINL) + HDR;
        live = {live, addr_o};
      end
    end else begin
      a = int'(beat[31:17]);
      ok = a >= HDR;
      off = ok ? a - HDR : 0;
      if (ok && (off >= SPACE || off % (1 << MINL) != 0)) ok = 0;
      g = off >> MINL;
      if (ok && (g >= GRAN || !head[g] || !occ[g])) ok = 0;
      if (!ok) st = bafm_pkg::ST_INVALID;
      else begin
        foreach (live[i]) if (live[i] == a) begin
          live.delete(i);
          break;
        end
        l = lvl_of[g]; occ[g] = 0;
        free_sum += 1 << (MINL + l);
        while (l < LVLS) begin
          b = g ^ (1 << l);
          if (!head[b] || occ[b] || lvl_of[b] != l) break;
          if (b < g) begin
            head[g] = 0; g = b;
          end else head[b] = 0;
          l++;
          lvl_of[g] = l; occ[g] = 0;
        end
      end
    end
    beat_exp = {7'd0, free_sum[15:0], granted[15:0], addr_o[14:0], st};
    pending = {pending, beat_exp};
  endfunction

  function void check_result(logic [bafm_pkg::OUT_W-1:0] got);
    logic [bafm_pkg::OUT_W-1:0] exp;
    if (pending.size() == 0) begin
      $error("unexpected result beat %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    case (exp[1:0])
      bafm_pkg::ST_OK:    n_ok++;
      bafm_pkg::ST_NOMEM: n_nomem++;
      default:            n_bad++;
    endcase
    if (got[1:0] !== exp[1:0]) begin
      $error("status exp %0d got %0d", exp[1:0], got[1:0]); errors++;
    end
    if (got[16:2] !== exp[16:2]) begin
      $error("data_address exp %0d got %0d", exp[16:2], got[16:2]); errors++;
    end
    if (got[32:17] !== exp[32:17]) begin
      $error("granted_bytes exp %0d got %0d", exp[32:17], got[32:17]); errors++;
    end
    if (got[48:33] !== exp[48:33]) begin
      $error("free_bytes exp %0d got %0d", exp[48:33], got[48:33]); errors++;
    end
    if (got[55:49] !== 7'd0) begin
      $error("pad exp 0 got %0d", got[55:49]); errors++;
    end
  endfunction
endclass

module tb;
  import bafm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_data = FIT_FIRST;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  alloc_scoreboard sb = new();
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit snk_hold = 0;
  int quiet = 0;
  int n_items = 0;
  localparam int QUIET_LIMIT = 20000;

  always #5 clk = ~clk;

  buddy_allocator_fit_modes dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // sink: randomized ready, result checking
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= !snk_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // valid stays up after an accept; the next send or drain decides its value
  task automatic send(logic op, logic [15:0] req, logic [14:0] fa);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {fa, req, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input({fa, req, op});
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.mode = m;
  endtask

  task automatic send_free_live();
    int k;
    if (sb.live.size() == 0) send(OP_ALLOC, 16'($urandom_range(600)), 15'd0);
    else begin
      k = $urandom_range(sb.live.size() - 1);
      send(OP_FREE, 16'($urandom), 15'(sb.live[k]));
    end
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      if ($urandom_range(9) == 0) send(OP_ALLOC, 16'($urandom), 15'($urandom));
      else send(OP_ALLOC, 16'($urandom_range(1 << $urandom_range(11))), 15'($urandom));
    end else if (r < 90) send_free_live();
    else send(OP_FREE, 16'($urandom), 15'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every mode, special cases
    send(OP_ALLOC, 16'd0, 15'd0);          // zero request down to one granule
    send(OP_ALLOC, 16'd32768, 15'h7fff);   // too large
    send(OP_ALLOC, 16'hffff, 15'd0);
    send(OP_FREE, 16'hffff, 15'd0);        // below header
    send(OP_FREE, 16'd0, 15'd17);          // off granule
    send(OP_FREE, 16'd0, 15'h7fff);
    send(OP_FREE, 16'd0, 15'd48);          // free block, not an occupied head
    send(OP_ALLOC, 16'd100, 15'd0);
    send(OP_ALLOC, 16'd3000, 15'd0);
    send(OP_FREE, 16'd0, 15'd16);
    send(OP_FREE, 16'd0, 15'd16);          // double free
    drain();
    write_mode(FIT_BEST);
    send(OP_ALLOC, 16'd10, 15'd0);
    send(OP_ALLOC, 16'd16000, 15'd0);
    send(OP_ALLOC, 16'd32752, 15'd0);
    drain();
    write_mode(FIT_WORST);
    send(OP_ALLOC, 16'd10, 15'd0);
    send(OP_ALLOC, 16'd500, 15'd0);
    drain();
    write_mode(FIT_SPARE);                 // unused code acts as first fit
    send(OP_ALLOC, 16'd40, 15'd0);
    repeat (4) send_free_live();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(2'(ph % 4));
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      if (ph == 4) fork
        begin
          snk_hold = 1;
          repeat (400) @(posedge clk);
          snk_hold = 0;
        end
      join_none
      repeat (215) random_op();
      drain();
    end

    $display("tb: %0d beats over all fit modes; ok %0d, out of memory %0d, bad free %0d",
             n_items, sb.n_ok, sb.n_nomem, sb.n_bad);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial sb.clear();
endmodule
